// File: sv/euler_angles_to_plane_frame_defines.svh
// assertion helpers for the euler angles to plane frame block
`ifndef EULER_ANGLES_TO_PLANE_FRAME_DEFINES_SVH
`define EULER_ANGLES_TO_PLANE_FRAME_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define EAPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EAPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/eapf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapf_pkg
// shared constants, types and arithmetic helpers for the plane frame block
// ----------------------------------------------------------------------------
package eapf_pkg;

    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int AXIS_FRAC_BITS_DEF = 14;

    localparam int XY_W = 33;
    localparam int Z_W  = 34;

    localparam int TURN_UNITS = 46080;
    localparam int DegDiv     = 45;
    localparam logic [13:0] RECIP45 = 14'd11651;

    localparam logic signed [XY_W-1:0] X_INIT = 33'sh026DD3B6A;

    typedef logic [31:0] atan_tab_t [24];
    localparam atan_tab_t ATAN_TAB = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic [21:0] frac_tab_t [64];

    // fractional part of r * 2^22 / 45, rounded as the angle scaling needs
    function automatic frac_tab_t build_frac_tab();
        frac_tab_t t;
        for (int i = 0; i < 64; i++)
        begin
            if (i < DegDiv)
            begin
                t[i] = 22'((64'(i) * 64'd4194304 + 64'd22) / DegDiv);
            end
            else
            begin
                t[i] = '0;
            end
        end
        return t;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac_tab();

    typedef struct packed {
        logic [31:0]        width;
        logic [31:0]        height;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } side_t;

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return 32'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [XY_W-1:0] v,
                                                     input logic flip);
        logic signed [XY_W-1:0] c;
        c = v;
        if (v > 33'sd1073741824)
        begin
            c = 33'sd1073741824;
        end
        else if (v < -33'sd1073741824)
        begin
            c = -33'sd1073741824;
        end
        if (flip)
        begin
            c = -c;
        end
        return 32'(c);
    endfunction

    // q24.24 product to q16.16, nonpositive gives 1.0, overflow saturates
    function automatic logic [31:0] extent_fin(input logic signed [48:0] p);
        logic signed [40:0] r;
        r = 41'((p + 49'sd128) >>> 8);
        if (r <= 41'sd0)
        begin
            return 32'h0001_0000;
        end
        if (r > 41'sd4294967295)
        begin
            return 32'hFFFF_FFFF;
        end
        return r[31:0];
    endfunction

endpackage

// File: sv/eapf_angle_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapf_angle_prep
// reduces an angle to one turn, scales it to a binary angle and folds it
// into the right half plane, three register stages
// ----------------------------------------------------------------------------
module eapf_angle_prep (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [16:0]              angle,
    output logic signed [eapf_pkg::Z_W-1:0] z_out,
    output logic                            flip_out
);

    logic signed [18:0] shifted;
    logic [17:0]        t;
    logic [15:0]        ua_next;
    logic [15:0]        ua_reg;
    logic [29:0]        prod;
    logic [9:0]         m_next;
    logic [9:0]         m_reg;
    logic [15:0]        ua2_reg;
    logic [15:0]        m45;
    logic [5:0]         r;
    logic [31:0]        th;
    logic               flip_next;
    logic [31:0]        thf;
    logic signed [eapf_pkg::Z_W-1:0] z_next;
    logic signed [eapf_pkg::Z_W-1:0] z_reg;
    logic               flip_reg;

    always_comb
    begin
        shifted = 19'(angle) + 19'sd92160;
        t       = 18'(shifted);
        if (t >= 18'd138240)
        begin
            ua_next = 16'(t - 18'd138240);
        end
        else if (t >= 18'd92160)
        begin
            ua_next = 16'(t - 18'd92160);
        end
        else if (t >= 18'd46080)
        begin
            ua_next = 16'(t - 18'd46080);
        end
        else
        begin
            ua_next = 16'(t);
        end
    end

    // quotient by 45 through a reciprocal, exact for a value below one turn
    assign prod   = 30'(ua_reg) * 30'(eapf_pkg::RECIP45);
    assign m_next = prod[28:19];

    always_comb
    begin
        m45       = 16'(m_reg) * 16'd45;
        r         = 6'(ua2_reg - m45);
        th        = {m_reg, 22'b0} + 32'(eapf_pkg::FRAC_TAB[r]);
        flip_next = th[31] ^ th[30];
        thf       = {th[31] ^ flip_next, th[30:0]};
        z_next    = eapf_pkg::Z_W'($signed(thf));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= ua_next;
            m_reg    <= m_next;
            ua2_reg  <= ua_reg;
            z_reg    <= z_next;
            flip_reg <= flip_next;
        end
    end

    assign z_out    = z_reg;
    assign flip_out = flip_reg;

endmodule

// File: sv/eapf_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapf_cordic_cell
// one rotation-mode cordic micro-rotation with its output register
// ----------------------------------------------------------------------------
module eapf_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [eapf_pkg::XY_W-1:0] x_in,
    input  logic signed [eapf_pkg::XY_W-1:0] y_in,
    input  logic signed [eapf_pkg::Z_W-1:0]  z_in,
    input  logic                             flip_in,
    output logic signed [eapf_pkg::XY_W-1:0] x_out,
    output logic signed [eapf_pkg::XY_W-1:0] y_out,
    output logic signed [eapf_pkg::Z_W-1:0]  z_out,
    output logic                             flip_out
);

    localparam logic signed [eapf_pkg::Z_W-1:0] ATAN =
        eapf_pkg::Z_W'(eapf_pkg::ATAN_TAB[STAGE]);

    logic signed [eapf_pkg::XY_W-1:0] dx;
    logic signed [eapf_pkg::XY_W-1:0] dy;
    logic signed [eapf_pkg::XY_W-1:0] x_next;
    logic signed [eapf_pkg::XY_W-1:0] y_next;
    logic signed [eapf_pkg::Z_W-1:0]  z_next;
    logic signed [eapf_pkg::XY_W-1:0] x_reg;
    logic signed [eapf_pkg::XY_W-1:0] y_reg;
    logic signed [eapf_pkg::Z_W-1:0]  z_reg;
    logic                             flip_reg;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (z_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            flip_reg <= flip_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign flip_out = flip_reg;

endmodule

// File: sv/euler_angles_to_plane_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_plane_frame
// turns xyz euler angles and scaled extents into a plane's u, v, normal
// axes and its width and height
// ----------------------------------------------------------------------------
// usage:
//   input stream s_*: one transaction per item, angles, extents and scales
//   output stream m_*: one transaction per item, axes in q2.14, extents q16.16
//   every item gives exactly one result, in order
//   pipeline from input transaction to m_tvalid: 3 angle prep,
//   CORDIC_STAGES cordic cells, clamp, 4 multiply stages, output register
//   throughput: one item per cycle while s_tready is high, set by the cordic
//   cell chain where every cell takes a new angle each enabled cycle
//   a stalled receiver holds the output register; one more result goes
//   to a skid register, and s_tready drops only while that is full
//   reset clears all valid bits; the data registers are not reset and keep their state
// ----------------------------------------------------------------------------
`include "euler_angles_to_plane_frame_defines.svh"

module euler_angles_to_plane_frame #(
    parameter int CORDIC_STAGES  = eapf_pkg::CORDIC_STAGES_DEF,
    parameter int AXIS_FRAC_BITS = eapf_pkg::AXIS_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // angle_x[16:0], angle_y[33:17], angle_z[50:34], primitive_width[82:51],
    // primitive_height[114:83], scale_x[130:115], scale_y[146:131], zero fill
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // u_x, u_y, u_z, v_x, v_y, v_z, n_x, n_y, n_z (16 bits each, from bit 0),
    // plane_width[175:144], plane_height[207:176]
    output logic [207:0] m_tdata
);

    localparam int S         = CORDIC_STAGES;
    localparam int LAT       = S + 8;
    localparam int SB_DEPTH  = S + 6;
    localparam int OUT_SHIFT = 30 - AXIS_FRAC_BITS;
    localparam logic signed [35:0] ROUND_ADD = 36'sd1 <<< (OUT_SHIFT - 1);
    localparam logic signed [35:0] AX_HI =
        (AXIS_FRAC_BITS >= 15) ? 36'sd32767 : (36'sd1 <<< AXIS_FRAC_BITS);
    localparam logic signed [35:0] AX_LO =
        (AXIS_FRAC_BITS >= 15) ? -36'sd32768 : -(36'sd1 <<< AXIS_FRAC_BITS);

    function automatic logic [15:0] axis_out(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + ROUND_ADD) >>> OUT_SHIFT;
        if (r > AX_HI)
        begin
            r = AX_HI;
        end
        else if (r < AX_LO)
        begin
            r = AX_LO;
        end
        return r[15:0];
    endfunction

    logic en;
    logic [LAT-1:0] vld_reg;

    logic signed [eapf_pkg::XY_W-1:0] x_w    [S+1][3];
    logic signed [eapf_pkg::XY_W-1:0] y_w    [S+1][3];
    logic signed [eapf_pkg::Z_W-1:0]  z_w    [S+1][3];
    logic                             flip_w [S+1][3];

    eapf_pkg::side_t sb_in;
    eapf_pkg::side_t sb_reg [SB_DEPTH];

    logic signed [31:0] c_reg [3];
    logic signed [31:0] s_reg [3];

    logic signed [31:0] u0_reg, u1_reg, u2_reg, sxsy_reg, czcx_reg, szcx_reg;
    logic signed [31:0] v2_reg, cz1_reg, sz1_reg;

    logic signed [31:0] u0b_reg, u1b_reg, u2b_reg;
    logic signed [32:0] v0_reg, v1_reg, v2b_reg;

    logic signed [31:0] u0c_reg, u1c_reg, u2c_reg;
    logic signed [32:0] v0c_reg, v1c_reg, v2c_reg;
    logic signed [63:0] pnx_a_reg, pnx_b_reg, pny_a_reg, pny_b_reg;
    logic signed [63:0] pnz_a_reg, pnz_b_reg;
    logic signed [48:0] pw_reg, ph_reg;

    logic [207:0] res_reg;
    logic [207:0] res_next;
    logic [207:0] out_data_reg;
    logic [207:0] skid_data_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         out_free;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    assign sb_in.width  = s_tdata[82:51];
    assign sb_in.height = s_tdata[114:83];
    assign sb_in.sx     = $signed(s_tdata[130:115]);
    assign sb_in.sy     = $signed(s_tdata[146:131]);

    // angle prep and cordic lanes, one per axis
    genvar gi, gj;
    generate
        for (gj = 0; gj < 3; gj++)
        begin : g_lane
            eapf_angle_prep u_prep (
                .clk      (clk),
                .en       (en),
                .angle    ($signed(s_tdata[17*gj +: 17])),
                .z_out    (z_w[0][gj]),
                .flip_out (flip_w[0][gj])
            );
            assign x_w[0][gj] = eapf_pkg::X_INIT;
            assign y_w[0][gj] = '0;

            for (gi = 0; gi < S; gi++)
            begin : g_cell
                eapf_cordic_cell #(
                    .STAGE (gi)
                ) u_cell (
                    .clk      (clk),
                    .en       (en),
                    .x_in     (x_w[gi][gj]),
                    .y_in     (y_w[gi][gj]),
                    .z_in     (z_w[gi][gj]),
                    .flip_in  (flip_w[gi][gj]),
                    .x_out    (x_w[gi+1][gj]),
                    .y_out    (y_w[gi+1][gj]),
                    .z_out    (z_w[gi+1][gj]),
                    .flip_out (flip_w[gi+1][gj])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_comb
    begin
        res_next[15:0]    = axis_out(36'(u0c_reg));
        res_next[31:16]   = axis_out(36'(u1c_reg));
        res_next[47:32]   = axis_out(36'(u2c_reg));
        res_next[63:48]   = axis_out(36'(v0c_reg));
        res_next[79:64]   = axis_out(36'(v1c_reg));
        res_next[95:80]   = axis_out(36'(v2c_reg));
        res_next[111:96]  = axis_out(36'((pnx_a_reg - pnx_b_reg + 64'sd536870912) >>> 30));
        res_next[127:112] = axis_out(36'((pny_a_reg - pny_b_reg + 64'sd536870912) >>> 30));
        res_next[143:128] = axis_out(36'((pnz_a_reg - pnz_b_reg + 64'sd536870912) >>> 30));
        res_next[175:144] = eapf_pkg::extent_fin(pw_reg);
        res_next[207:176] = eapf_pkg::extent_fin(ph_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int k = 1; k < SB_DEPTH; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end

            // clamp and undo the half-turn fold
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= eapf_pkg::clamp_q30(x_w[S][k], flip_w[S][k]);
                s_reg[k] <= eapf_pkg::clamp_q30(y_w[S][k], flip_w[S][k]);
            end

            u0_reg   <= eapf_pkg::qmul(c_reg[2], c_reg[1]);
            u1_reg   <= eapf_pkg::qmul(s_reg[2], c_reg[1]);
            u2_reg   <= -s_reg[1];
            sxsy_reg <= eapf_pkg::qmul(s_reg[0], s_reg[1]);
            czcx_reg <= eapf_pkg::qmul(c_reg[2], c_reg[0]);
            szcx_reg <= eapf_pkg::qmul(s_reg[2], c_reg[0]);
            v2_reg   <= eapf_pkg::qmul(s_reg[0], c_reg[1]);
            cz1_reg  <= c_reg[2];
            sz1_reg  <= s_reg[2];

            u0b_reg <= u0_reg;
            u1b_reg <= u1_reg;
            u2b_reg <= u2_reg;
            v0_reg  <= 33'(eapf_pkg::qmul(cz1_reg, sxsy_reg)) - 33'(szcx_reg);
            v1_reg  <= 33'(eapf_pkg::qmul(sz1_reg, sxsy_reg)) + 33'(czcx_reg);
            v2b_reg <= 33'(v2_reg);

            u0c_reg   <= u0b_reg;
            u1c_reg   <= u1b_reg;
            u2c_reg   <= u2b_reg;
            v0c_reg   <= v0_reg;
            v1c_reg   <= v1_reg;
            v2c_reg   <= v2b_reg;
            pnx_a_reg <= 64'(u1b_reg) * 64'(v2b_reg);
            pnx_b_reg <= 64'(u2b_reg) * 64'(v1_reg);
            pny_a_reg <= 64'(u2b_reg) * 64'(v0_reg);
            pny_b_reg <= 64'(u0b_reg) * 64'(v2b_reg);
            pnz_a_reg <= 64'(u0b_reg) * 64'(v1_reg);
            pnz_b_reg <= 64'(u1b_reg) * 64'(v0_reg);
            pw_reg    <= 49'($signed({1'b0, sb_reg[SB_DEPTH-1].width}))
                         * 49'(sb_reg[SB_DEPTH-1].sx);
            ph_reg    <= 49'($signed({1'b0, sb_reg[SB_DEPTH-1].height}))
                         * 49'(sb_reg[SB_DEPTH-1].sy);

            res_reg <= res_next;
        end
    end

    // output register with one skid entry behind it
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || vld_reg[LAT-1];
            skid_valid_reg <= 1'b0;
        end
        else if (vld_reg[LAT-1] && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_reg;
        end
        else if (en)
        begin
            skid_data_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `EAPF_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `EAPF_ASSERT_NXT(a_freeze_holds, !en, $stable(vld_reg) && $stable(res_reg), "pipeline moved while frozen")
    `EAPF_ASSERT_IMP(a_ux_bound, m_tvalid, ($signed(m_tdata[15:0]) <= AX_HI) && ($signed(m_tdata[15:0]) >= AX_LO), "u_x out of range")
    `EAPF_ASSERT_IMP(a_nz_bound, m_tvalid, ($signed(m_tdata[143:128]) <= AX_HI) && ($signed(m_tdata[143:128]) >= AX_LO), "n_z out of range")

endmodule
